[rtl/core/lota_pkg.sv]
// ============================================================================
// LoRa time-on-air package
// Item types, arithmetic widths and constants shared by the airtime pipeline.
// ============================================================================
package lota_pkg;

   // Field widths of the request and response items.
   localparam int SF_W     = 4;
   localparam int CR_W     = 3;
   localparam int PL_W     = 8;
   localparam int AIR_W    = 28;
   localparam int SYM_W    = 12;
   localparam int BW_W     = 19;

   typedef struct packed {
      logic [SF_W-1:0] spreading_factor;
      logic [CR_W-1:0] coding_rate;
      logic [PL_W-1:0] payload_length;
   } req_type;

   typedef struct packed {
      logic [AIR_W-1:0] airtime_us;
      logic [SYM_W-1:0] symbol_count;
   } rsp_type;

   // Protocol constants.
   localparam int PREAMBLE_SYMBOLS = 8;
   localparam logic [BW_W-1:0] BW_RESET = BW_W'(125000);
   localparam logic [SF_W-1:0] SF_MIN   = SF_W'(6);
   localparam logic [SF_W-1:0] SF_MAX   = SF_W'(12);
   localparam logic [SF_W-1:0] SF_LDRO  = SF_W'(11);
   localparam logic [CR_W-1:0] CR_MIN   = CR_W'(1);
   localparam logic [CR_W-1:0] CR_MAX   = CR_W'(4);
   localparam int SYM_FIXED = 8;
   localparam int NUM_BIAS  = 44;
   localparam logic [AIR_W-1:0] AIR_MAX = '1;

   // Reciprocal multiply for the symbol-block divide (divisor 6 to 10).
   localparam int DIVK_W      = 4;
   localparam int M4_W        = 10;
   localparam int RECIP_W     = 14;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_K_W    = M4_W + RECIP_W;
   localparam int BLK_W       = 8;

   // Airtime numerator: quarter symbols times 2^SF times one million.
   localparam int QUARTERS_BASE = 4 * PREAMBLE_SYMBOLS + 17;
   localparam int QUARTERS_W    = $clog2(QUARTERS_BASE + 4 * ((1 << SYM_W) - 1) + 1);
   localparam int SHIFT_W       = QUARTERS_W + int'(SF_MAX);
   localparam int US_PER_S      = 1000000;
   localparam int US_W          = 20;
   localparam int PROD_W        = SHIFT_W + US_W;
   localparam int NUM_W         = PROD_W + 1;
   localparam int DEN_W         = BW_W + 2;
   localparam int DIV_W         = (NUM_W > DEN_W + AIR_W) ? NUM_W : DEN_W + AIR_W;
   localparam int DIV_STAGES    = AIR_W;

   // Accept to strobe: six arithmetic stages, the saturation check, one
   // divider stage per quotient bit and the output register.
   localparam int LATENCY = 6 + 1 + DIV_STAGES + 1;

   // ceil(2^16 / k) for the divisors that can occur; the error term keeps
   // the truncated product exact for every quotient operand below 1024.
   function automatic logic [RECIP_W-1:0] recip_of(input logic [DIVK_W-1:0] k);
      logic [RECIP_W-1:0] r;
      unique case (k)
         DIVK_W'(6):  r = RECIP_W'(10923);
         DIVK_W'(7):  r = RECIP_W'(9363);
         DIVK_W'(9):  r = RECIP_W'(7282);
         DIVK_W'(10): r = RECIP_W'(6554);
         default:     r = RECIP_W'(8192);
      endcase
      return r;
   endfunction

endpackage

[rtl/core/lora_time_on_air.sv]
// ============================================================================
// LoRa time-on-air calculator
// Pipelined airtime and payload symbol count for explicit-header frames.
// ============================================================================
// Usage: a request item (spreading factor, coding rate, payload length) is
// taken at a rising edge with start high and busy low. busy never rises, so
// one item can be taken in every cycle. Each item yields one response item
// on rsp_data, marked by rsp_strobe for exactly one cycle; responses leave
// in request order. The receiver cannot hold responses off and does not
// need to: nothing inside the pipeline ever waits. The airtime divide by
// 4 * bandwidth retires one quotient bit per stage over 28 stages behind six
// arithmetic stages and the saturation check, ahead of the output register.
// The bandwidth register is written through csr_we / csr_wdata; it must be
// changed only while no item is in flight. Reset empties the pipeline (all
// valid bits cleared) and loads 125000 Hz into the bandwidth register.
// Out-of-range spreading factors and coding rates are clamped to the legal
// range; a zero bandwidth or an airtime above the field maximum gives the
// saturated value.
// ============================================================================
module lora_time_on_air
   import lota_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_type         req_data,
   output logic            rsp_strobe,
   output rsp_type         rsp_data,
   input  logic            csr_we,
   input  logic [BW_W-1:0] csr_wdata
);

   // Configuration register.
   logic [BW_W-1:0] bw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff <= BW_RESET;
      end else if (csr_we) begin
         bw_ff <= csr_wdata;
      end
   end

   // The pipeline never stalls, so a request is always welcome.
   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // Stage 1: clamp the inputs and form the rounded-up numerator of the
   // symbol-block count. The divisor is 4 * k with k = SF - 2 * DE, so the
   // low two bits are dropped here and only k remains to divide by.
   logic [SF_W-1:0]   sf_clamp;
   logic [CR_W-1:0]   cr_clamp;
   logic [DIVK_W-1:0] k_in;
   logic [11:0]       pos, neg, num_blk, m_full;
   logic              s1_vld_ff, s1_nonpos_ff, s1_nonpos_in;
   logic [SF_W-1:0]   s1_sf_ff;
   logic [CR_W-1:0]   s1_cr_ff;
   logic [M4_W-1:0]   s1_m4_ff, s1_m4_in;
   logic [DIVK_W-1:0] s1_k_ff;

   always_comb begin
      priority if (req_data.spreading_factor < SF_MIN) begin
         sf_clamp = SF_MIN;
      end else if (req_data.spreading_factor > SF_MAX) begin
         sf_clamp = SF_MAX;
      end else begin
         sf_clamp = req_data.spreading_factor;
      end
      priority if (req_data.coding_rate < CR_MIN) begin
         cr_clamp = CR_MIN;
      end else if (req_data.coding_rate > CR_MAX) begin
         cr_clamp = CR_MAX;
      end else begin
         cr_clamp = req_data.coding_rate;
      end
      // Low data rate optimization lowers k from SF to SF - 2.
      k_in         = (sf_clamp >= SF_LDRO) ? sf_clamp - SF_W'(2) : sf_clamp;
      pos          = {1'b0, req_data.payload_length, 3'b000} + 12'(NUM_BIAS);
      neg          = {6'b000000, sf_clamp, 2'b00};
      s1_nonpos_in = (pos <= neg);
      num_blk      = pos - neg;
      m_full       = num_blk + {6'b000000, k_in, 2'b00} - 12'd1;
      s1_m4_in     = m_full[11:2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_sf_ff     <= sf_clamp;
      s1_cr_ff     <= cr_clamp;
      s1_nonpos_ff <= s1_nonpos_in;
      s1_m4_ff     <= s1_m4_in;
      s1_k_ff      <= k_in;
   end

   // Stage 2: divide by k through a reciprocal multiply.
   logic                s2_vld_ff, s2_nonpos_ff;
   logic [SF_W-1:0]     s2_sf_ff;
   logic [CR_W-1:0]     s2_cr_ff;
   logic [PROD_K_W-1:0] s2_prod_ff, s2_prod_in;

   assign s2_prod_in = PROD_K_W'(s1_m4_ff) * PROD_K_W'(recip_of(s1_k_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_sf_ff     <= s1_sf_ff;
      s2_cr_ff     <= s1_cr_ff;
      s2_nonpos_ff <= s1_nonpos_ff;
      s2_prod_ff   <= s2_prod_in;
   end

   // Stage 3: payload symbols = 8 + blocks * (CR + 4).
   logic [BLK_W-1:0] blocks;
   logic [3:0]       cr_plus4;
   logic             s3_vld_ff;
   logic [SF_W-1:0]  s3_sf_ff;
   logic [SYM_W-1:0] s3_sym_ff, s3_sym_in;

   always_comb begin
      blocks   = BLK_W'(s2_prod_ff >> RECIP_SHIFT);
      cr_plus4 = {1'b0, s2_cr_ff} + 4'd4;
      if (s2_nonpos_ff) begin
         s3_sym_in = SYM_W'(SYM_FIXED);
      end else begin
         s3_sym_in = SYM_W'(SYM_FIXED) + SYM_W'(blocks) * SYM_W'(cr_plus4);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_sf_ff  <= s2_sf_ff;
      s3_sym_ff <= s3_sym_in;
   end

   // Stage 4: frame length in quarter symbols (preamble, 4.25 sync symbols
   // and payload), scaled by the chips per symbol.
   logic [QUARTERS_W-1:0] quarters;
   logic                  s4_vld_ff;
   logic [SYM_W-1:0]      s4_sym_ff;
   logic [SHIFT_W-1:0]    s4_chips_ff, s4_chips_in;

   always_comb begin
      quarters    = QUARTERS_W'(QUARTERS_BASE) + QUARTERS_W'({s3_sym_ff, 2'b00});
      s4_chips_in = SHIFT_W'(quarters) << s3_sf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_sym_ff   <= s3_sym_ff;
      s4_chips_ff <= s4_chips_in;
   end

   // Stage 5: scale to microseconds.
   logic              s5_vld_ff;
   logic [SYM_W-1:0]  s5_sym_ff;
   logic [PROD_W-1:0] s5_prod_ff, s5_prod_in;

   assign s5_prod_in = PROD_W'(s4_chips_ff) * PROD_W'(US_PER_S);

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s5_sym_ff  <= s4_sym_ff;
      s5_prod_ff <= s5_prod_in;
   end

   // Stage 6: add half the divisor (2 * bandwidth) for round to nearest.
   logic             s6_vld_ff;
   logic [SYM_W-1:0] s6_sym_ff;
   logic [NUM_W-1:0] s6_num_ff, s6_num_in;

   assign s6_num_in = NUM_W'(s5_prod_ff) + NUM_W'({bw_ff, 1'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s6_sym_ff <= s5_sym_ff;
      s6_num_ff <= s6_num_in;
   end

   // Divider: entry 0 holds the saturation check, entry d + 1 the result
   // of the restoring step for quotient bit AIR_W - 1 - d. A zero divisor
   // always trips the saturation check.
   logic [DIV_W-1:0] den;
   assign den = DIV_W'({bw_ff, 2'b00});

   logic             div_vld_ff [DIV_STAGES+1];
   logic             div_sat_ff [DIV_STAGES+1];
   logic             div_sat_in [DIV_STAGES+1];
   logic [NUM_W-1:0] div_rem_ff [DIV_STAGES+1];
   logic [NUM_W-1:0] div_rem_in [DIV_STAGES+1];
   logic [AIR_W-1:0] div_quo_ff [DIV_STAGES+1];
   logic [AIR_W-1:0] div_quo_in [DIV_STAGES+1];
   logic [SYM_W-1:0] div_sym_ff [DIV_STAGES+1];
   logic [SYM_W-1:0] div_sym_in [DIV_STAGES+1];

   always_comb begin
      logic [DIV_W-1:0] trial;
      logic             fits;
      div_sat_in[0] = (DIV_W'(s6_num_ff) >= (den << AIR_W));
      div_rem_in[0] = s6_num_ff;
      div_quo_in[0] = '0;
      div_sym_in[0] = s6_sym_ff;
      for (int d = 0; d < DIV_STAGES; d++) begin
         trial             = den << (AIR_W - 1 - d);
         fits              = (DIV_W'(div_rem_ff[d]) >= trial);
         div_sat_in[d + 1] = div_sat_ff[d];
         div_sym_in[d + 1] = div_sym_ff[d];
         div_quo_in[d + 1] = {div_quo_ff[d][AIR_W-2:0], fits};
         div_rem_in[d + 1] = fits ? NUM_W'(DIV_W'(div_rem_ff[d]) - trial) : div_rem_ff[d];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d <= DIV_STAGES; d++) begin
            div_vld_ff[d] <= 1'b0;
         end
      end else begin
         div_vld_ff[0] <= s6_vld_ff;
         for (int d = 0; d < DIV_STAGES; d++) begin
            div_vld_ff[d + 1] <= div_vld_ff[d];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int d = 0; d <= DIV_STAGES; d++) begin
         div_sat_ff[d] <= div_sat_in[d];
         div_rem_ff[d] <= div_rem_in[d];
         div_quo_ff[d] <= div_quo_in[d];
         div_sym_ff[d] <= div_sym_in[d];
      end
   end

   // Output register: apply saturation and present the item for one cycle.
   logic    rsp_strobe_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_data_in.airtime_us   = div_sat_ff[DIV_STAGES] ? AIR_MAX
                                                        : div_quo_ff[DIV_STAGES];
      rsp_data_in.symbol_count = div_sym_ff[DIV_STAGES];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= div_vld_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // Every accepted item comes out after the fixed latency.
   a_accept_to_strobe: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("accepted item did not produce a response on time");

   // No response appears without an accepted item behind it.
   a_strobe_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("response without an accepted item");

   // A finished, unsaturated divide leaves a remainder below the divisor.
   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (div_vld_ff[DIV_STAGES] && !div_sat_ff[DIV_STAGES])
         |-> (DIV_W'(div_rem_ff[DIV_STAGES]) < den))
      else $error("divider remainder not below divisor");

   // The symbol count always includes the fixed symbols.
   a_symbols_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.symbol_count >= SYM_W'(SYM_FIXED)))
      else $error("payload symbol count below the fixed symbols");

endmodule
